// ===== rtl/mqrc_pkg.sv =====
// Types, constants and step table for the multi-encoder quadrature decoder.
`default_nettype none
package mqrc_pkg;

	localparam int NUM_ENCODERS_DEF = 8;
	localparam int DELTA_LIMIT = 7;
	localparam int ENC_W = 3;
	localparam int CNT_W = 4;
	localparam int MAG_W = 3;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 7;

	localparam logic [CFG_IDX_W-1:0] REG_MIDI_CHANNEL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_CONTROLLER = 2'd1;

	localparam logic [3:0] MIDI_CHANNEL_RST = 4'd0;
	localparam logic [6:0] BASE_CONTROLLER_RST = 7'd16;
	localparam logic [6:0] CC_CW = 7'd65;
	localparam logic [6:0] CC_CCW = 7'd63;
	localparam logic [1:0] PHASE_IDLE = 2'd3;

	typedef logic signed [1:0] step_t;

	localparam step_t STEP_TABLE [16] = '{
		2'sd0, -2'sd1, 2'sd1, 2'sd0,
		2'sd1, 2'sd0, 2'sd0, -2'sd1,
		-2'sd1, 2'sd0, 2'sd0, 2'sd1,
		2'sd0, 2'sd1, -2'sd1, 2'sd0
	};

	typedef struct packed {
		logic func;
		logic [ENC_W-1:0] encoder_index;
		logic level_a;
		logic level_b;
	} in_item_t;

	typedef struct packed {
		logic [3:0] channel;
		logic [6:0] controller;
		logic [6:0] cc_value;
		logic last;
	} out_item_t;

	typedef struct packed {
		logic [1:0] prev_phase;
		logic signed [CNT_W-1:0] step_count;
	} entry_t;

	localparam entry_t ENTRY_RST = '{prev_phase: PHASE_IDLE, step_count: '0};

	typedef struct packed {
		logic rd_en;
		logic wr_en;
	} mem_ctl_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PIN_RD,
		S_PIN_WR,
		S_TICK_RD,
		S_TICK_LD,
		S_TICK_EMIT
	} state_t;

endpackage
`default_nettype wire

// ===== rtl/mqrc_state_mem.sv =====
// Per-encoder state memory with registered read and reset-valid bits.
`default_nettype none
module mqrc_state_mem #(
	parameter int NUM_ENCODERS = mqrc_pkg::NUM_ENCODERS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire mqrc_pkg::mem_ctl_t ctl,
	input wire logic [(NUM_ENCODERS > 1 ? $clog2(NUM_ENCODERS) : 1)-1:0] addr,
	input wire mqrc_pkg::entry_t wr_data,
	output mqrc_pkg::entry_t rd_data
);

	mqrc_pkg::entry_t mem_q [NUM_ENCODERS];
	mqrc_pkg::entry_t rd_q;
	logic rd_vld_q;
	logic [NUM_ENCODERS-1:0] valid_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem_q[addr] <= wr_data;
		end
		if (ctl.rd_en) begin
			rd_q <= mem_q[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (ctl.wr_en) begin
				valid_q[addr] <= 1'b1;
			end
			if (ctl.rd_en) begin
				rd_vld_q <= valid_q[addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_q : mqrc_pkg::ENTRY_RST;

endmodule
`default_nettype wire

// ===== rtl/mqrc_seq.sv =====
// Sequencer: read-modify-write of encoder state and tick drain into messages.
`default_nettype none
module mqrc_seq #(
	parameter int NUM_ENCODERS = mqrc_pkg::NUM_ENCODERS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire mqrc_pkg::in_item_t in_data,
	output logic out_valid,
	input wire logic out_ready,
	output mqrc_pkg::out_item_t out_data,
	input wire logic [3:0] midi_channel,
	input wire logic [6:0] base_controller,
	output mqrc_pkg::mem_ctl_t mem_ctl,
	output logic [(NUM_ENCODERS > 1 ? $clog2(NUM_ENCODERS) : 1)-1:0] mem_addr,
	output mqrc_pkg::entry_t mem_wr_data,
	input wire mqrc_pkg::entry_t mem_rd_data
);

	localparam int ADDR_W = NUM_ENCODERS > 1 ? $clog2(NUM_ENCODERS) : 1;
	localparam logic signed [4:0] LIM_POS = 5'(mqrc_pkg::DELTA_LIMIT);
	localparam logic signed [4:0] LIM_NEG = -5'(mqrc_pkg::DELTA_LIMIT);
	localparam logic [ADDR_W-1:0] ENC_LAST = ADDR_W'(NUM_ENCODERS - 1);

	mqrc_pkg::state_t state_q, state_d;
	mqrc_pkg::in_item_t item_q;
	logic [ADDR_W-1:0] enc_q;
	logic [mqrc_pkg::MAG_W-1:0] cnt_q;
	logic cw_q;
	logic [NUM_ENCODERS-1:0] nz_q;
	logic out_valid_q;
	mqrc_pkg::out_item_t out_q;

	logic in_xfer, out_free, in_range, emit;
	logic [ADDR_W-1:0] item_addr;
	logic [1:0] cur_phase;
	mqrc_pkg::step_t step;
	logic signed [4:0] sum, sat;
	logic signed [mqrc_pkg::CNT_W-1:0] cnt_rd, cnt_abs;

	assign in_xfer = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign in_range = {1'b0, in_data.encoder_index} < 4'(NUM_ENCODERS);
	assign item_addr = item_q.encoder_index[ADDR_W-1:0];
	assign cur_phase = {item_q.level_a, item_q.level_b};
	assign step = mqrc_pkg::STEP_TABLE[{mem_rd_data.prev_phase, cur_phase}];
	assign sum = 5'(mem_rd_data.step_count) + 5'(step);
	assign sat = (sum > LIM_POS) ? LIM_POS : ((sum < LIM_NEG) ? LIM_NEG : sum);
	assign cnt_rd = mem_rd_data.step_count;
	assign cnt_abs = cnt_rd[mqrc_pkg::CNT_W-1] ? -cnt_rd : cnt_rd;
	assign emit = (state_q == mqrc_pkg::S_TICK_EMIT) && (cnt_q != '0) && out_free;

	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		mem_ctl = '0;
		mem_addr = enc_q;
		mem_wr_data = mqrc_pkg::ENTRY_RST;
		case (state_q)
			mqrc_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_data.func) begin
						state_d = mqrc_pkg::S_TICK_RD;
					end else if (in_range) begin
						state_d = mqrc_pkg::S_PIN_RD;
					end
				end
			end
			mqrc_pkg::S_PIN_RD: begin
				mem_ctl.rd_en = 1'b1;
				mem_addr = item_addr;
				state_d = mqrc_pkg::S_PIN_WR;
			end
			mqrc_pkg::S_PIN_WR: begin
				mem_ctl.wr_en = 1'b1;
				mem_addr = item_addr;
				mem_wr_data.prev_phase = cur_phase;
				mem_wr_data.step_count = sat[mqrc_pkg::CNT_W-1:0];
				state_d = mqrc_pkg::S_IDLE;
			end
			mqrc_pkg::S_TICK_RD: begin
				mem_ctl.rd_en = 1'b1;
				state_d = mqrc_pkg::S_TICK_LD;
			end
			mqrc_pkg::S_TICK_LD: begin
				mem_ctl.wr_en = 1'b1;
				mem_wr_data.prev_phase = mem_rd_data.prev_phase;
				mem_wr_data.step_count = '0;
				state_d = mqrc_pkg::S_TICK_EMIT;
			end
			mqrc_pkg::S_TICK_EMIT: begin
				if (cnt_q == '0) begin
					state_d = (enc_q == ENC_LAST) ? mqrc_pkg::S_IDLE : mqrc_pkg::S_TICK_RD;
				end
			end
			default: begin
				state_d = mqrc_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mqrc_pkg::S_IDLE;
			enc_q <= '0;
			cnt_q <= '0;
			nz_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_xfer) begin
				enc_q <= '0;
			end
			if (state_q == mqrc_pkg::S_PIN_WR) begin
				nz_q[item_addr] <= (sat != '0);
			end
			if (state_q == mqrc_pkg::S_TICK_LD) begin
				cnt_q <= cnt_abs[mqrc_pkg::MAG_W-1:0];
				nz_q[enc_q] <= 1'b0;
			end
			if (state_q == mqrc_pkg::S_TICK_EMIT && cnt_q == '0 && enc_q != ENC_LAST) begin
				enc_q <= enc_q + 1'b1;
			end
			if (emit) begin
				cnt_q <= cnt_q - 1'b1;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			item_q <= in_data;
		end
		if (state_q == mqrc_pkg::S_TICK_LD) begin
			cw_q <= !cnt_rd[mqrc_pkg::CNT_W-1];
		end
		if (emit) begin
			out_q.channel <= midi_channel;
			out_q.controller <= base_controller + 7'(enc_q);
			out_q.cc_value <= cw_q ? mqrc_pkg::CC_CW : mqrc_pkg::CC_CCW;
			out_q.last <= (cnt_q == mqrc_pkg::MAG_W'(1)) && (nz_q == '0);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule
`default_nettype wire

// ===== rtl/multi_quadrature_to_relative_cc.sv =====
// Top level of the multi-encoder quadrature decoder with relative control messages.
// Decodes up to NUM_ENCODERS quadrature encoders whose state sits in a single-port
// memory with a registered read. A pin sample (func 0) passes through transfer,
// state read and saturating update written back; an out-of-range encoder index is
// dropped in the transfer cycle. A tick (func 1) walks every encoder through read,
// clear and check steps, emitting one message per count unit while the output
// is free; messages carry midi_channel, base_controller plus encoder index modulo
// 128, and 65 or 63 per count unit, with last set on the final message. A tick with
// all counts zero emits nothing.
// Configuration writes are taken in any cycle and belong only to idle periods.
`default_nettype none
module multi_quadrature_to_relative_cc #(
	parameter int NUM_ENCODERS = mqrc_pkg::NUM_ENCODERS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire mqrc_pkg::in_item_t in_data,
	output logic out_valid,
	input wire logic out_ready,
	output mqrc_pkg::out_item_t out_data,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [mqrc_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [mqrc_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int ADDR_W = NUM_ENCODERS > 1 ? $clog2(NUM_ENCODERS) : 1;

	logic [3:0] midi_channel_q;
	logic [6:0] base_controller_q;
	mqrc_pkg::mem_ctl_t mem_ctl;
	logic [ADDR_W-1:0] mem_addr;
	mqrc_pkg::entry_t mem_wr_data, mem_rd_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			midi_channel_q <= mqrc_pkg::MIDI_CHANNEL_RST;
			base_controller_q <= mqrc_pkg::BASE_CONTROLLER_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				mqrc_pkg::REG_MIDI_CHANNEL: midi_channel_q <= cfg_data[3:0];
				mqrc_pkg::REG_BASE_CONTROLLER: base_controller_q <= cfg_data;
				default: ;
			endcase
		end
	end

	mqrc_seq #(
		.NUM_ENCODERS(NUM_ENCODERS)
	) u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.midi_channel(midi_channel_q),
		.base_controller(base_controller_q),
		.mem_ctl(mem_ctl),
		.mem_addr(mem_addr),
		.mem_wr_data(mem_wr_data),
		.mem_rd_data(mem_rd_data)
	);

	mqrc_state_mem #(
		.NUM_ENCODERS(NUM_ENCODERS)
	) u_state_mem (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(mem_ctl),
		.addr(mem_addr),
		.wr_data(mem_wr_data),
		.rd_data(mem_rd_data)
	);

endmodule
`default_nettype wire

// ===== test/multi_quadrature_to_relative_cc_tb.sv =====
// Testbench for the multi-encoder quadrature decoder: random pin and tick traffic, message checks.
`timescale 1ns / 1ps
module multi_quadrature_to_relative_cc_tb;
	import mqrc_pkg::*;

	localparam int NUM_ENC = NUM_ENCODERS_DEF;
	localparam int SETTLE_CYCLES = 48;
	localparam int QUIET_LIMIT = 3000;
	localparam int MAX_PRINTED = 100;
	localparam logic FUNC_PIN = 1'b0;
	localparam logic FUNC_TICK = 1'b1;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd2;

	typedef enum int {
		READY_ALWAYS,
		READY_PATTERN,
		READY_SPARSE
	} ready_mode_t;

	typedef struct {
		in_item_t item;
		bit drain_first;
	} sample_entry_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	sample_entry_t pending_samples[$];
	out_item_t expected_messages[$];

	logic [1:0] enc_phase [NUM_ENC];
	logic signed [CNT_W-1:0] enc_count [NUM_ENC];
	logic [3:0] cfg_channel;
	logic [6:0] cfg_base;

	logic [1:0] sent_phase [NUM_ENC];
	int items_queued = 0;

	int gap_max = 0;
	int gap_left = 0;
	int burst_left = 8;
	ready_mode_t stall_mode = READY_ALWAYS;
	logic [15:0] ready_bits = '1;
	int ready_left = 0;
	int quiet_cycles = 0;
	int error_count = 0;
	int messages_seen = 0;

	multi_quadrature_to_relative_cc uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// position along the Gray cycle 0-1-3-2; the mapping is its own inverse
	function automatic logic [1:0] phase_position(input logic [1:0] p);
		return {p[1], p[1] ^ p[0]};
	endfunction

	function automatic int gray_step(input logic [1:0] prev, input logic [1:0] cur);
		logic [1:0] diff;
		diff = phase_position(cur) - phase_position(prev);
		case (diff)
		2'd1: return -1;
		2'd3: return 1;
		default: return 0;
		endcase
	endfunction

	function automatic logic [1:0] next_phase(input logic [1:0] p, input logic clockwise);
		return phase_position(phase_position(p) + (clockwise ? 2'd3 : 2'd1));
	endfunction

	task automatic decode_sample(input in_item_t s);
		logic [1:0] cur;
		int total;
		int n;
		out_item_t msg;
		if (s.func == FUNC_PIN) begin
			if (int'(s.encoder_index) < NUM_ENC) begin
				cur = {s.level_a, s.level_b};
				total = int'(enc_count[s.encoder_index]) + gray_step(enc_phase[s.encoder_index], cur);
				if (total > DELTA_LIMIT)
					total = DELTA_LIMIT;
				if (total < -DELTA_LIMIT)
					total = -DELTA_LIMIT;
				enc_count[s.encoder_index] = CNT_W'(total);
				enc_phase[s.encoder_index] = cur;
			end
		end else begin
			n = 0;
			for (int e = 0; e < NUM_ENC; e++) begin
				total = int'(enc_count[e]);
				enc_count[e] = '0;
				while (total != 0) begin
					msg.channel = cfg_channel;
					msg.controller = cfg_base + 7'(e);
					msg.cc_value = (total > 0) ? CC_CW : CC_CCW;
					msg.last = 1'b0;
					expected_messages.push_back(msg);
					total = (total > 0) ? total - 1 : total + 1;
					n++;
				end
			end
			if (n > 0)
				expected_messages[expected_messages.size() - 1].last = 1'b1;
		end
	endtask

	task automatic report(input string what);
		error_count++;
		if (error_count <= MAX_PRINTED)
			$display("%0t ns: %s", $time, what);
	endtask

	task automatic check_field(input string name, input int got, input int want);
		if (got != want)
			report($sformatf("message %0d: %s is %0d, expected %0d", messages_seen, name, got,
				want));
	endtask

	task automatic queue_sample(input in_item_t s, input bit drain_first);
		sample_entry_t entry;
		entry.item = s;
		entry.drain_first = drain_first;
		pending_samples.push_back(entry);
		items_queued++;
	endtask

	task automatic queue_pin(input int enc, input logic [1:0] p);
		in_item_t s;
		s.func = FUNC_PIN;
		s.encoder_index = ENC_W'(enc);
		{s.level_a, s.level_b} = p;
		sent_phase[enc] = p;
		queue_sample(s, 1'b0);
	endtask

	task automatic queue_tick(input bit drain_first);
		in_item_t s;
		s = in_item_t'($urandom);
		s.func = FUNC_TICK;
		queue_sample(s, drain_first);
	endtask

	task automatic turn_encoder(input int enc, input logic clockwise, input int steps);
		logic dir;
		repeat (steps) begin
			dir = ($urandom_range(0, 9) == 0) ? !clockwise : clockwise;
			queue_pin(enc, next_phase(sent_phase[enc], dir));
		end
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] reg_index,
			input logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= reg_index;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!(cfg_valid && cfg_ready));
		cfg_valid <= 1'b0;
		case (reg_index)
		REG_MIDI_CHANNEL: cfg_channel = value[3:0];
		REG_BASE_CONTROLLER: cfg_base = value;
		default: ;
		endcase
	endtask

	task automatic wait_idle();
		while (pending_samples.size() != 0 || in_valid || expected_messages.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_phase(input logic [CFG_DATA_W-1:0] channel_value,
			input logic [CFG_DATA_W-1:0] base_value, input int gap, input ready_mode_t mode,
			input int count);
		int start;
		int pick;
		in_item_t noise;
		write_register(REG_MIDI_CHANNEL, channel_value);
		write_register(REG_BASE_CONTROLLER, base_value);
		gap_max = gap;
		stall_mode = mode;
		start = items_queued;
		while (items_queued - start < count) begin
			pick = $urandom_range(0, 15);
			if (pick < 10) begin
				turn_encoder($urandom_range(0, NUM_ENC - 1), 1'($urandom), $urandom_range(1, 12));
			end else if (pick < 12) begin
				noise = in_item_t'($urandom);
				noise.func = FUNC_PIN;
				queue_pin(int'(noise.encoder_index), {noise.level_a, noise.level_b});
			end else if (pick == 12) begin
				pick = $urandom_range(0, NUM_ENC - 1);
				queue_pin(pick, ~sent_phase[pick]);
			end else begin
				queue_tick(pick == 15);
			end
		end
		queue_tick(1'b0);
		wait_idle();
	endtask

	always @(posedge clk) begin : driver
		logic next_valid;
		in_item_t next_data;
		sample_entry_t entry;
		if (arst_n) begin
			next_valid = in_valid;
			next_data = in_data;
			if (in_valid && in_ready) begin
				decode_sample(in_data);
				next_valid = 1'b0;
				if (burst_left > 0)
					burst_left--;
				if (burst_left == 0) begin
					gap_left = $urandom_range(0, gap_max);
					burst_left = $urandom_range(1, 12);
				end
			end
			if (!next_valid) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_samples.size() != 0 &&
						(!pending_samples[0].drain_first || expected_messages.size() == 0)) begin
					entry = pending_samples.pop_front();
					next_data = entry.item;
					next_valid = 1'b1;
				end
			end
			in_valid <= next_valid;
			in_data <= next_data;
		end
	end

	always @(posedge clk) begin : monitor
		out_item_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				messages_seen++;
				if (expected_messages.size() == 0) begin
					report($sformatf("unexpected message %0d: controller %0d value %0d",
						messages_seen, out_data.controller, out_data.cc_value));
				end else begin
					want = expected_messages.pop_front();
					check_field("channel", out_data.channel, want.channel);
					check_field("controller", out_data.controller, want.controller);
					check_field("cc_value", out_data.cc_value, want.cc_value);
					check_field("last", out_data.last, want.last);
				end
			end
			if (ready_left == 0) begin
				case (stall_mode)
				READY_PATTERN: ready_bits = 16'($urandom);
				READY_SPARSE: ready_bits = 16'($urandom & $urandom & $urandom);
				default: ready_bits = '1;
				endcase
				ready_left = 16;
			end
			out_ready <= ready_bits[0];
			ready_bits = {ready_bits[0], ready_bits[15:1]};
			ready_left--;
		end
	end

	always @(posedge clk) begin : watchdog
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	initial begin
		for (int e = 0; e < NUM_ENC; e++) begin
			enc_phase[e] = PHASE_IDLE;
			enc_count[e] = '0;
			sent_phase[e] = PHASE_IDLE;
		end
		cfg_channel = MIDI_CHANNEL_RST;
		cfg_base = BASE_CONTROLLER_RST;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// hold phase, then three counterclockwise steps
		queue_pin(0, 2'd3);
		queue_pin(0, 2'd2);
		queue_pin(0, 2'd0);
		queue_pin(0, 2'd1);
		// jump both phases, then one clockwise step
		queue_pin(1, 2'd0);
		queue_pin(1, 2'd2);
		queue_tick(1'b0);
		queue_tick(1'b0);
		// drive past the count limit in both directions
		repeat (8) queue_pin(7, next_phase(sent_phase[7], 1'b1));
		repeat (8) queue_pin(6, next_phase(sent_phase[6], 1'b0));
		queue_pin(3, 2'd0);
		queue_tick(1'b0);
		wait_idle();

		run_phase(7'h7F, 7'd120, 0, READY_ALWAYS, 100);
		run_phase(7'h00, 7'h00, 4, READY_PATTERN, 100);
		run_phase(7'h05, 7'h7F, 12, READY_SPARSE, 100);
		write_register(REG_SPARE, 7'h2A);
		run_phase(7'h3A, 7'h55, 30, READY_PATTERN, 100);
		run_phase(7'h09, 7'd121, 2, READY_SPARSE, 100);

		if (expected_messages.size() != 0)
			report($sformatf("%0d messages never arrived", expected_messages.size()));
		if (error_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
